/* hdl/cpfa_pkg.sv */
// shared types and constants of the contiguous page frame allocator
package cpfa_pkg;

  localparam int MODE_W     = 2;
  localparam int OWNER_ID_W = 4;
  localparam int BYTE_W     = 32;
  localparam int ADDR_W     = 20;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_ROUND = 4095;
  localparam int PAGE_IDX_W = ADDR_W - PAGE_SHIFT;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_FREE    = 2'd1,
    MODE_RESERVE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CLAIM,
    ST_FREE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic scan_start;
    logic free_start;
    logic rd_en;
    logic scan_step;
    logic claim_wr;
    logic free_wr;
    logic resv_wr;
    logic finish;
    logic fin_ok;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              who_zero;
    logic              pages_bad;
    logic              idx_bad;
    logic              clear_last;
    logic              rd_more;
    logic              exhausted;
    logic              hit;
    logic              claim_last;
    logic              free_go;
    logic              free_stop;
    logic              free_stop_ok;
    logic              out_free;
  } sts_t;

endpackage

/* hdl/cpfa_if.sv */
// request and response channel interfaces of the page frame allocator
interface cpfa_req_if;
  logic                             valid;
  logic                             ready;
  logic [cpfa_pkg::MODE_W-1:0]      mode;
  logic [cpfa_pkg::OWNER_ID_W-1:0]  owner_id;
  logic [cpfa_pkg::BYTE_W-1:0]      byte_count;
  logic [cpfa_pkg::ADDR_W-1:0]      address;

  modport source (output valid, mode, owner_id, byte_count, address, input ready);
  modport sink (input valid, mode, owner_id, byte_count, address, output ready);
endinterface

interface cpfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [cpfa_pkg::ADDR_W-1:0]  base_address;

  modport source (output valid, status, base_address, input ready);
  modport sink (input valid, status, base_address, output ready);
endinterface

/* hdl/cpfa_ctrl.sv */
// controller state machine of the page frame allocator
module cpfa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cpfa_pkg::sts_t sts_i,
  output cpfa_pkg::cmd_t cmd_o
);

  cpfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpfa_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpfa_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) state_d = cpfa_pkg::ST_IDLE;
      end
      cpfa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cpfa_pkg::ST_DECODE;
      end
      cpfa_pkg::ST_DECODE: begin
        case (sts_i.mode)
          cpfa_pkg::MODE_ALLOC: begin
            if (sts_i.who_zero || sts_i.pages_bad) state_d = cpfa_pkg::ST_RESULT;
            else state_d = cpfa_pkg::ST_SCAN;
          end
          cpfa_pkg::MODE_FREE: begin
            if (sts_i.who_zero || sts_i.idx_bad) state_d = cpfa_pkg::ST_RESULT;
            else state_d = cpfa_pkg::ST_FREE;
          end
          default: state_d = cpfa_pkg::ST_RESULT;
        endcase
      end
      cpfa_pkg::ST_SCAN: begin
        if (sts_i.hit) state_d = cpfa_pkg::ST_CLAIM;
        else if (sts_i.exhausted) state_d = cpfa_pkg::ST_RESULT;
      end
      cpfa_pkg::ST_CLAIM: begin
        if (sts_i.claim_last) state_d = cpfa_pkg::ST_RESULT;
      end
      cpfa_pkg::ST_FREE: begin
        if (sts_i.free_stop || sts_i.exhausted) state_d = cpfa_pkg::ST_RESULT;
      end
      cpfa_pkg::ST_RESULT: begin
        if (sts_i.out_free) state_d = cpfa_pkg::ST_IDLE;
      end
      default: state_d = cpfa_pkg::ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cpfa_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
      end
      cpfa_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      cpfa_pkg::ST_DECODE: begin
        case (sts_i.mode)
          cpfa_pkg::MODE_ALLOC: begin
            if (sts_i.who_zero || sts_i.pages_bad) cmd_o.finish = 1'b1;
            else cmd_o.scan_start = 1'b1;
          end
          cpfa_pkg::MODE_FREE: begin
            if (sts_i.who_zero || sts_i.idx_bad) cmd_o.finish = 1'b1;
            else cmd_o.free_start = 1'b1;
          end
          cpfa_pkg::MODE_RESERVE: begin
            cmd_o.finish  = 1'b1;
            cmd_o.fin_ok  = !sts_i.idx_bad;
            cmd_o.resv_wr = !sts_i.idx_bad;
          end
          default: cmd_o.finish = 1'b1;
        endcase
      end
      cpfa_pkg::ST_SCAN: begin
        cmd_o.rd_en     = sts_i.rd_more;
        cmd_o.scan_step = 1'b1;
        if (!sts_i.hit && sts_i.exhausted) cmd_o.finish = 1'b1;
      end
      cpfa_pkg::ST_CLAIM: begin
        cmd_o.claim_wr = 1'b1;
        if (sts_i.claim_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_ok = 1'b1;
        end
      end
      cpfa_pkg::ST_FREE: begin
        cmd_o.rd_en   = sts_i.rd_more;
        cmd_o.free_wr = sts_i.free_go;
        if (sts_i.free_stop) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_ok = sts_i.free_stop_ok;
        end else if (sts_i.exhausted) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_ok = 1'b1;
        end
      end
      cpfa_pkg::ST_RESULT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

/* hdl/cpfa_dpath.sv */
// frame table memories, scan counters and result register of the allocator
module cpfa_dpath #(
  parameter int NUM_FRAMES = 256,
  parameter int OWNER_BITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cpfa_pkg::cmd_t                      cmd_i,
  output cpfa_pkg::sts_t                      sts_o,
  input  logic [cpfa_pkg::MODE_W-1:0]         mode_i,
  input  logic [cpfa_pkg::OWNER_ID_W-1:0]     owner_id_i,
  input  logic [cpfa_pkg::BYTE_W-1:0]         byte_count_i,
  input  logic [cpfa_pkg::ADDR_W-1:0]         address_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                status_o,
  output logic [cpfa_pkg::ADDR_W-1:0]         base_address_o
);

  localparam int FB    = $clog2(NUM_FRAMES);
  localparam int CNT_W = FB + 1;
  localparam int RW    = cpfa_pkg::BYTE_W + 1;
  localparam int OW    = OWNER_BITS + cpfa_pkg::OWNER_ID_W;
  localparam logic [CNT_W-1:0] NF      = CNT_W'(NUM_FRAMES);
  localparam logic [CNT_W-1:0] NF_LAST = CNT_W'(NUM_FRAMES - 1);

  // frame table
  logic [OWNER_BITS-1:0] owner_mem [NUM_FRAMES];
  logic [FB-1:0]         bst_mem   [NUM_FRAMES];
  logic                  frb_mem   [NUM_FRAMES];

  logic [OWNER_BITS-1:0] owner_rd_q;
  logic [FB-1:0]         bst_rd_q;
  logic                  frb_rd_q;

  // request registers
  logic [cpfa_pkg::MODE_W-1:0] mode_q;
  logic [OWNER_BITS-1:0]       who_q;
  logic [CNT_W-1:0]            pages_q;
  logic                        who_zero_q, pages_bad_q, idx_bad_q;
  logic [FB-1:0]               first_q, last_q;

  // scan and write control
  logic [CNT_W-1:0] rd_idx_q, wr_idx_q, run_q;
  logic             rd_vld_q;
  logic [FB-1:0]    chk_idx_q;

  logic                        res_ok_q;
  logic [cpfa_pkg::ADDR_W-1:0] res_base_q;
  logic                        out_valid_q, status_q;
  logic [cpfa_pkg::ADDR_W-1:0] out_base_q;

  // request decode
  logic [OW-1:0]                   who_wide;
  logic [OWNER_BITS-1:0]           who_d;
  logic [RW-1:0]                   bytes_rnd;
  logic [RW-1:0]                   pages_full;
  logic [cpfa_pkg::PAGE_IDX_W-1:0] idx_in;

  assign who_wide   = OW'(owner_id_i);
  assign who_d      = who_wide[OWNER_BITS-1:0];
  assign bytes_rnd  = RW'(byte_count_i) + RW'(cpfa_pkg::PAGE_ROUND);
  assign pages_full = bytes_rnd >> cpfa_pkg::PAGE_SHIFT;
  assign idx_in     = address_i[cpfa_pkg::ADDR_W-1:cpfa_pkg::PAGE_SHIFT];

  // scan and free evaluation on the registered read data
  logic          frame_ok, hit, match, at_first;
  logic [FB-1:0] hit_first;
  logic [31:0]   base_full;

  assign frame_ok  = rd_vld_q && (owner_rd_q == '0) && frb_rd_q;
  assign hit       = frame_ok && ((run_q + CNT_W'(1)) == pages_q);
  assign hit_first = FB'(CNT_W'(chk_idx_q) - run_q);
  assign match     = (bst_rd_q == first_q) && (owner_rd_q == who_q);
  assign at_first  = (chk_idx_q == first_q);
  assign base_full = 32'(first_q) << cpfa_pkg::PAGE_SHIFT;

  always_comb begin
    sts_o              = '0;
    sts_o.mode         = mode_q;
    sts_o.who_zero     = who_zero_q;
    sts_o.pages_bad    = pages_bad_q;
    sts_o.idx_bad      = idx_bad_q;
    sts_o.clear_last   = (wr_idx_q == NF_LAST);
    sts_o.rd_more      = (rd_idx_q < NF);
    sts_o.exhausted    = !rd_vld_q && (rd_idx_q == NF);
    sts_o.hit          = hit;
    sts_o.claim_last   = (wr_idx_q[FB-1:0] == last_q);
    sts_o.free_go      = rd_vld_q && match && frb_rd_q;
    sts_o.free_stop    = rd_vld_q && (!match || !frb_rd_q);
    sts_o.free_stop_ok = !match && !at_first;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  // table write ports
  logic                  own_we, bst_we, frb_we;
  logic [FB-1:0]         own_wa, frb_wa;
  logic [OWNER_BITS-1:0] own_wd;
  logic [FB-1:0]         bst_wd;
  logic                  frb_wd;

  always_comb begin
    own_we = cmd_i.clr_wr || cmd_i.claim_wr || cmd_i.free_wr;
    own_wa = cmd_i.free_wr ? chk_idx_q : wr_idx_q[FB-1:0];
    own_wd = cmd_i.claim_wr ? who_q : '0;
    bst_we = cmd_i.clr_wr || cmd_i.claim_wr;
    bst_wd = cmd_i.claim_wr ? first_q : '0;
    frb_we = cmd_i.clr_wr || cmd_i.resv_wr;
    frb_wa = cmd_i.resv_wr ? first_q : wr_idx_q[FB-1:0];
    frb_wd = !cmd_i.resv_wr;
  end

  always_ff @(posedge clk_i) begin
    if (own_we) owner_mem[own_wa] <= own_wd;
    if (bst_we) bst_mem[wr_idx_q[FB-1:0]] <= bst_wd;
    if (frb_we) frb_mem[frb_wa] <= frb_wd;
    if (cmd_i.rd_en) begin
      owner_rd_q <= owner_mem[rd_idx_q[FB-1:0]];
      bst_rd_q   <= bst_mem[rd_idx_q[FB-1:0]];
      frb_rd_q   <= frb_mem[rd_idx_q[FB-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q      <= mode_i;
      who_q       <= who_d;
      pages_q     <= CNT_W'(pages_full);
      who_zero_q  <= (who_d == '0);
      pages_bad_q <= (byte_count_i == '0) || (pages_full > RW'(NUM_FRAMES));
      idx_bad_q   <= (32'(idx_in) >= 32'(NUM_FRAMES));
    end
    if (cmd_i.capture) begin
      first_q <= FB'(idx_in);
    end else if (cmd_i.scan_step && hit) begin
      first_q <= hit_first;
    end
    if (cmd_i.scan_step && hit) last_q <= chk_idx_q;
    if (cmd_i.finish) begin
      res_ok_q   <= cmd_i.fin_ok;
      res_base_q <= (cmd_i.fin_ok && (mode_q == cpfa_pkg::MODE_ALLOC))
                    ? base_full[cpfa_pkg::ADDR_W-1:0] : '0;
    end
    if (cmd_i.load_out) begin
      status_q   <= !res_ok_q;
      out_base_q <= res_base_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      chk_idx_q   <= '0;
      run_q       <= '0;
      wr_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.free_start) begin
        rd_idx_q <= CNT_W'(first_q);
      end else if (cmd_i.rd_en) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) chk_idx_q <= rd_idx_q[FB-1:0];
      if (cmd_i.scan_start) begin
        run_q <= '0;
      end else if (cmd_i.scan_step && rd_vld_q) begin
        run_q <= frame_ok ? run_q + CNT_W'(1) : '0;
      end
      // claim walks from the run start found by the scan
      if (cmd_i.scan_step && hit) begin
        wr_idx_q <= CNT_W'(hit_first);
      end else if (cmd_i.clr_wr || cmd_i.claim_wr) begin
        wr_idx_q <= wr_idx_q + CNT_W'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign base_address_o = out_base_q;

endmodule

/* hdl/contiguous_page_frame_allocator_top.sv */
// top level of the first-fit contiguous page frame allocator
// Requests arrive on req_i (valid/ready): mode, owner_id, byte_count, address.
// One response per request leaves on rsp_o (valid/ready): status and base_address.
// The block works on one request at a time; req_i.ready is high only when idle.
// Steps from transfer to response valid:
//   allocate: a first-fit scan reading one table entry per cycle, followed by
//   one write per claimed frame
//   free: one frame released per cycle
//   reserve and rejected requests: settled in the decode state, with no table scan
// After reset a clearing pass writes all NUM_FRAMES table entries, one per cycle,
// and req_i.ready stays low until that pass ends.
// A finished response sits in an output register; while rsp_o is stalled the
// block still takes the next request and holds its result until the register
// frees up.
module contiguous_page_frame_allocator_top #(
  parameter int NUM_FRAMES = 256,
  parameter int OWNER_BITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpfa_req_if.sink    req_i,
  cpfa_rsp_if.source  rsp_o
);

  cpfa_pkg::cmd_t cmd;
  cpfa_pkg::sts_t sts;

  cpfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cpfa_dpath #(
    .NUM_FRAMES (NUM_FRAMES),
    .OWNER_BITS (OWNER_BITS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (req_i.mode),
    .owner_id_i     (req_i.owner_id),
    .byte_count_i   (req_i.byte_count),
    .address_i      (req_i.address),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .status_o       (rsp_o.status),
    .base_address_o (rsp_o.base_address)
  );

endmodule
